// ----- design/bmmc_pkg.sv -----
package bmmc_pkg;

  localparam int CART_RAM_BANKS_DEF = 4;
  localparam int ROM_BANK_BITS_DEF  = 7;

  localparam int OFFSET_W       = 14;
  localparam int ROM_BANK_W_MAX = 7;
  localparam int ROM_ADDR_W     = OFFSET_W + ROM_BANK_W_MAX;
  localparam int RAM_OFFSET_W   = 13;
  localparam int RAM_BANK_SIZE  = 8192;
  localparam int CLEAR_DEPTH    = 8192;
  localparam int SPRITE_DEPTH   = 160;
  localparam int HIGH_DEPTH     = 127;

  localparam logic [15:0] VIDEO_BASE  = 16'h8000;
  localparam logic [15:0] CART_BASE   = 16'hA000;
  localparam logic [15:0] WORK_BASE   = 16'hC000;
  localparam logic [15:0] SPRITE_BASE = 16'hFE00;
  localparam logic [15:0] UNUSED_BASE = 16'hFEA0;
  localparam logic [15:0] IO_BASE     = 16'hFF00;
  localparam logic [15:0] HIGH_BASE   = 16'hFF80;
  localparam logic [15:0] IE_ADDR     = 16'hFFFF;

  // Bank controller register select, address bits 14:13 below 0x8000.
  localparam logic [1:0] SEL_RAM_ENABLE = 2'd0;
  localparam logic [1:0] SEL_ROM_LOW    = 2'd1;
  localparam logic [1:0] SEL_UPPER      = 2'd2;
  localparam logic [1:0] SEL_MODE       = 2'd3;

  localparam logic [3:0] RAM_ENABLE_KEY = 4'hA;
  localparam logic [7:0] OPEN_BUS       = 8'hFF;

  typedef enum logic [3:0] {
    RG_ROM,
    RG_VIDEO,
    RG_CART,
    RG_WORK,
    RG_SPRITE,
    RG_UNUSED,
    RG_IO,
    RG_HIGH,
    RG_IE
  } region_t;

  typedef struct packed {
    logic        valid;
    logic        write;
    logic [15:0] address;
    logic [7:0]  data;
  } req_t;

  typedef struct packed {
    logic       ok;
    logic [1:0] bank;
  } cart_ctl_t;

  function automatic region_t region_of(input logic [15:0] a);
    region_t r;
    if (a < VIDEO_BASE) r = RG_ROM;
    else if (a < CART_BASE) r = RG_VIDEO;
    else if (a < WORK_BASE) r = RG_CART;
    else if (a < SPRITE_BASE) r = RG_WORK;
    else if (a < UNUSED_BASE) r = RG_SPRITE;
    else if (a < IO_BASE) r = RG_UNUSED;
    else if (a < HIGH_BASE) r = RG_IO;
    else if (a < IE_ADDR) r = RG_HIGH;
    else r = RG_IE;
    return r;
  endfunction

endpackage

// ----- design/banked_memory_map_controller.sv -----
// Channel   Ports                                         Handshake
// request   in_action, in_address, in_write_data          start high while busy low
// result    out_read_data, out_rom_read, out_rom_address  out_strobe, one cycle
// config    cfg_wdata                                     cfg_we
//
// One request may be taken every clock; its result passes through the request
// register, the registered store read and the result register.
// Reset is synchronous; after it busy stays high while the internal stores but
// cart_mem are swept to zero, one address per cycle.
// The receiver cannot stall, so busy is high only during that sweep.
module banked_memory_map_controller
  import bmmc_pkg::*;
#(
  parameter int CART_RAM_BANKS = CART_RAM_BANKS_DEF,
  parameter int ROM_BANK_BITS  = ROM_BANK_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic                  in_action,
  input  logic [15:0]           in_address,
  input  logic [7:0]            in_write_data,
  output logic                  out_strobe,
  output logic [7:0]            out_read_data,
  output logic                  out_rom_read,
  output logic [ROM_ADDR_W-1:0] out_rom_address,
  input  logic                  cfg_we,
  input  logic [2:0]            cfg_wdata
);

  req_t                  req_r;
  cart_ctl_t             cart;
  logic [ROM_ADDR_W-1:0] rom_address;
  logic [7:0]            rd_data;
  logic                  clearing;
  logic                  s2_valid_r;
  logic                  s2_write_r;
  logic                  s2_rom_r;
  logic [ROM_ADDR_W-1:0] s2_rom_addr_r;
  logic                  s2_read;

  assign busy = clearing;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_r.valid <= 1'b0;
    end else begin
      req_r.valid <= start && !busy;
    end
    if (start && !busy) begin
      req_r.write   <= in_action;
      req_r.address <= in_address;
      req_r.data    <= in_write_data;
    end
  end

  bmmc_bank #(
    .CART_RAM_BANKS(CART_RAM_BANKS),
    .ROM_BANK_BITS (ROM_BANK_BITS)
  ) u_bank (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (req_r),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .rom_address(rom_address),
    .cart       (cart)
  );

  bmmc_store #(
    .CART_RAM_BANKS(CART_RAM_BANKS)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (req_r),
    .cart    (cart),
    .clearing(clearing),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= req_r.valid;
    end
    s2_write_r    <= req_r.write;
    s2_rom_r      <= (region_of(req_r.address) == RG_ROM);
    s2_rom_addr_r <= rom_address;
  end

  assign s2_read = s2_valid_r && !s2_write_r;

  // Writes report all zero; ROM reads carry only the cartridge address.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe   <= 1'b0;
      out_rom_read <= 1'b0;
    end else begin
      out_strobe   <= s2_valid_r;
      out_rom_read <= s2_read && s2_rom_r;
    end
    out_read_data   <= (s2_read && !s2_rom_r) ? rd_data : 8'h00;
    out_rom_address <= (s2_read && s2_rom_r) ? s2_rom_addr_r : '0;
  end

  a_strobe_follows_request: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start && !busy, 3))
    else $error("result strobe without a request three cycles earlier");

  a_rom_read_has_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_rom_read |-> (out_strobe && out_read_data == 8'h00))
    else $error("ROM read flagged outside a result or with read data");

  a_no_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !out_strobe)
    else $error("result delivered during the clearing pass");

endmodule

// ----- design/bmmc_bank.sv -----
module bmmc_bank
  import bmmc_pkg::*;
#(
  parameter int CART_RAM_BANKS = CART_RAM_BANKS_DEF,
  parameter int ROM_BANK_BITS  = ROM_BANK_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  req_t                  req,
  input  logic                  cfg_we,
  input  logic [2:0]            cfg_wdata,
  output logic [ROM_ADDR_W-1:0] rom_address,
  output cart_ctl_t             cart
);

  logic [2:0]               ram_bank_count_r;
  logic [ROM_BANK_BITS-1:0] rom_bank_r;
  logic [ROM_BANK_BITS-1:0] rom_bank_nxt;
  logic [1:0]               ram_bank_r;
  logic [1:0]               ram_bank_nxt;
  logic                     ram_enable_r;
  logic                     ram_enable_nxt;
  logic                     bank_mode_r;
  logic                     bank_mode_nxt;
  logic [ROM_BANK_W_MAX-1:0] bank_full;
  logic [ROM_BANK_W_MAX-1:0] bank_sel;
  logic [ROM_BANK_W_MAX-1:0] bank_wr;
  logic [4:0]               low_five;
  logic [2:0]               fitted;
  logic                     ctl_write;

  assign bank_full = ROM_BANK_W_MAX'(rom_bank_r);
  assign bank_sel  = req.address[OFFSET_W] ? bank_full : '0;
  assign rom_address = {bank_sel, req.address[OFFSET_W-1:0]};

  // A bank count beyond the fitted store is taken as the fitted store.
  assign fitted = (ram_bank_count_r > 3'(CART_RAM_BANKS)) ? 3'(CART_RAM_BANKS)
                                                          : ram_bank_count_r;

  always_comb begin
    cart.ok = ram_enable_r && (fitted != 3'd0);
    case (fitted)
      3'd1:    cart.bank = 2'd0;
      3'd2:    cart.bank = {1'b0, ram_bank_r[0]};
      3'd3:    cart.bank = (ram_bank_r == 2'd3) ? 2'd0 : ram_bank_r;
      default: cart.bank = ram_bank_r;
    endcase
  end

  assign ctl_write = req.valid && req.write && (req.address < VIDEO_BASE);
  assign low_five  = (req.data[4:0] == 5'd0) ? 5'd1 : req.data[4:0];

  always_comb begin
    ram_enable_nxt = ram_enable_r;
    ram_bank_nxt   = ram_bank_r;
    bank_mode_nxt  = bank_mode_r;
    bank_wr        = bank_full;
    if (ctl_write) begin
      case (req.address[OFFSET_W:RAM_OFFSET_W])
        SEL_RAM_ENABLE: ram_enable_nxt = (req.data[3:0] == RAM_ENABLE_KEY);
        SEL_ROM_LOW:    bank_wr = {bank_full[6:5], low_five};
        SEL_UPPER: begin
          if (bank_mode_r) ram_bank_nxt = req.data[1:0];
          else bank_wr = {req.data[1:0], bank_full[4:0]};
        end
        SEL_MODE:       bank_mode_nxt = req.data[0];
        default:        bank_mode_nxt = bank_mode_r;
      endcase
    end
    rom_bank_nxt = bank_wr[ROM_BANK_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ram_bank_count_r <= '0;
      rom_bank_r       <= ROM_BANK_BITS'(1);
      ram_bank_r       <= '0;
      ram_enable_r     <= 1'b0;
      bank_mode_r      <= 1'b0;
    end else begin
      if (cfg_we) ram_bank_count_r <= cfg_wdata;
      rom_bank_r   <= rom_bank_nxt;
      ram_bank_r   <= ram_bank_nxt;
      ram_enable_r <= ram_enable_nxt;
      bank_mode_r  <= bank_mode_nxt;
    end
  end

  // The wrapped RAM bank must always lie inside the fitted banks.
  a_cart_bank_fits: assert property (@(posedge clk) disable iff (!rst_n)
    cart.ok |-> ({1'b0, cart.bank} < fitted))
    else $error("cartridge RAM bank outside fitted banks");

endmodule

// ----- design/bmmc_store.sv -----
module bmmc_store
  import bmmc_pkg::*;
#(
  parameter int CART_RAM_BANKS = CART_RAM_BANKS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  req_t      req,
  input  cart_ctl_t cart,
  output logic      clearing,
  output logic [7:0] rd_data
);

  localparam int CART_DEPTH = CART_RAM_BANKS * RAM_BANK_SIZE;
  localparam int CART_IW    = $clog2(CART_DEPTH);
  localparam int CLR_W      = $clog2(CLEAR_DEPTH);
  localparam int SPR_W      = $clog2(SPRITE_DEPTH);
  localparam int HIGH_W     = $clog2(HIGH_DEPTH);

  logic [7:0] video_mem  [CLEAR_DEPTH];
  logic [7:0] work_mem   [CLEAR_DEPTH];
  logic [7:0] sprite_mem [SPRITE_DEPTH];
  logic [7:0] high_mem   [HIGH_DEPTH];
  logic [7:0] cart_mem   [CART_DEPTH];

  logic             clr_active_r;
  logic [CLR_W-1:0] clr_idx_r;
  logic [7:0]       ie_r;
  region_t          region;
  region_t          region_r;
  logic             cart_ok_r;
  logic [7:0]       video_q_r, work_q_r, sprite_q_r, high_q_r, cart_q_r, ie_q_r;
  logic             wr;
  logic             video_we, work_we, sprite_we, high_we, cart_we;
  logic [CLR_W-1:0] ram_waddr;
  logic [SPR_W-1:0] sprite_waddr;
  logic [HIGH_W-1:0] high_waddr;
  logic [7:0]       fill_data;
  logic [CART_IW-1:0] cart_idx;

  assign region   = region_of(req.address);
  assign wr       = req.valid && req.write;
  assign clearing = clr_active_r;

  // The clearing pass writes zero at the sweep index into all stores but cart_mem.
  assign video_we  = clr_active_r || (wr && region == RG_VIDEO);
  assign work_we   = clr_active_r || (wr && region == RG_WORK);
  assign sprite_we = (clr_active_r && clr_idx_r < CLR_W'(SPRITE_DEPTH))
                     || (wr && region == RG_SPRITE);
  assign high_we   = (clr_active_r && clr_idx_r < CLR_W'(HIGH_DEPTH))
                     || (wr && region == RG_HIGH);
  assign cart_we   = wr && region == RG_CART && cart.ok;

  assign ram_waddr    = clr_active_r ? clr_idx_r : req.address[RAM_OFFSET_W-1:0];
  assign sprite_waddr = clr_active_r ? clr_idx_r[SPR_W-1:0] : req.address[SPR_W-1:0];
  assign high_waddr   = clr_active_r ? clr_idx_r[HIGH_W-1:0] : req.address[HIGH_W-1:0];
  assign fill_data    = clr_active_r ? 8'h00 : req.data;
  assign cart_idx     = CART_IW'({cart.bank, req.address[RAM_OFFSET_W-1:0]});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_idx_r    <= '0;
      ie_r         <= '0;
    end else begin
      if (clr_active_r) begin
        clr_idx_r <= clr_idx_r + CLR_W'(1);
        if (clr_idx_r == CLR_W'(CLEAR_DEPTH - 1)) clr_active_r <= 1'b0;
      end
      if (wr && region == RG_IE) ie_r <= req.data;
    end
  end

  always_ff @(posedge clk) begin
    if (video_we) video_mem[ram_waddr] <= fill_data;
    video_q_r <= video_mem[req.address[RAM_OFFSET_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (work_we) work_mem[ram_waddr] <= fill_data;
    work_q_r <= work_mem[req.address[RAM_OFFSET_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (sprite_we) sprite_mem[sprite_waddr] <= fill_data;
    sprite_q_r <= sprite_mem[req.address[SPR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (high_we) high_mem[high_waddr] <= fill_data;
    high_q_r <= high_mem[req.address[HIGH_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cart_we) cart_mem[cart_idx] <= req.data;
    cart_q_r <= cart_mem[cart_idx];
  end

  always_ff @(posedge clk) begin
    region_r  <= region;
    cart_ok_r <= cart.ok;
    ie_q_r    <= ie_r;
  end

  always_comb begin
    case (region_r)
      RG_VIDEO:  rd_data = video_q_r;
      RG_CART:   rd_data = cart_ok_r ? cart_q_r : OPEN_BUS;
      RG_WORK:   rd_data = work_q_r;
      RG_SPRITE: rd_data = sprite_q_r;
      RG_UNUSED: rd_data = OPEN_BUS;
      RG_HIGH:   rd_data = high_q_r;
      RG_IE:     rd_data = ie_q_r;
      default:   rd_data = 8'h00;
    endcase
  end

  // No request may reach the stores while the clearing pass owns the write port.
  a_no_req_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clr_active_r |-> !req.valid)
    else $error("request reached the stores during the clearing pass");

endmodule
